// ----- hdl/affine_point_transform_3d_macros.svh -----
// Assertion helpers used by the top-level module.
`ifndef AFFINE_POINT_TRANSFORM_3D_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_3D_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define APT_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define APT_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/apt3d_pkg.sv -----
package apt3d_pkg;

	localparam int COORD_WIDTH    = 24;
	localparam int TRIG_FRAC_BITS = 14;
	localparam int COORD_FRAC     = 8;

	typedef enum logic [2:0] {
		MODE_IDENTITY  = 3'd0,
		MODE_TRANSLATE = 3'd1,
		MODE_SCALE     = 3'd2,
		MODE_ROTATE    = 3'd3,
		MODE_REFLECT   = 3'd4,
		MODE_SHEAR     = 3'd5
	} mode_t;

	localparam logic [1:0] AXIS_NONE = 2'd0;
	localparam logic [1:0] AXIS_X    = 2'd1;
	localparam logic [1:0] AXIS_Y    = 2'd2;
	localparam logic [1:0] AXIS_Z    = 2'd3;

	localparam logic [1:0] PLANE_NONE = 2'd0;
	localparam logic [1:0] PLANE_Z    = 2'd1;
	localparam logic [1:0] PLANE_X    = 2'd2;
	localparam logic [1:0] PLANE_Y    = 2'd3;

	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_AXIS    = 3'd1;
	localparam logic [2:0] REG_PLANE   = 3'd2;
	localparam logic [2:0] REG_PARAM_X = 3'd3;
	localparam logic [2:0] REG_PARAM_Y = 3'd4;
	localparam logic [2:0] REG_PARAM_Z = 3'd5;
	localparam logic [2:0] REG_COS     = 3'd6;
	localparam logic [2:0] REG_SIN     = 3'd7;

	typedef struct packed {
		mode_t      mode;
		logic [1:0] axis;
		logic [1:0] plane;
	} ctrl_t;

endpackage

// ----- hdl/affine_point_transform_3d.sv -----
// Three register stages: input register, product register, result register.
// An accepted input passes the input, product and result registers in turn; any stage can stall.
// Throughput: one point per cycle unless m_tready holds the output; one multiplier pair per coordinate sets the stage.
// Stages advance independently, so input is taken while a result waits at the output if an earlier stage is empty.
// Reset (arst_n low, asynchronous) empties all stages and loads register defaults.
`include "affine_point_transform_3d_macros.svh"

module affine_point_transform_3d
	import apt3d_pkg::*;
#(
	parameter int COORD_WIDTH    = apt3d_pkg::COORD_WIDTH,
	parameter int TRIG_FRAC_BITS = apt3d_pkg::TRIG_FRAC_BITS,
	localparam int DW       = ((3 * COORD_WIDTH + 7) / 8) * 8,
	localparam int PDATA_W  = (COORD_WIDTH > 32) ? 64 : 32,
	localparam int PADDR_W  = (COORD_WIDTH > 32) ? 6 : 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [DW-1:0]      s_tdata,   // point_x, point_y, point_z
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [DW-1:0]      m_tdata,   // out_x, out_y, out_z
	output logic [0:0]         m_tuser,   // clipped
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int W   = COORD_WIDTH;
	localparam int TW  = TRIG_FRAC_BITS + 2;
	localparam int MW  = (W > TW + 1) ? W : TW + 1;
	localparam int PRW = 2 * MW;
	localparam int PW  = PRW + 1;
	localparam int LW  = W + 2;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W:0]   ONE_T = (W+1)'(1) << COORD_FRAC;

	ctrl_t               ctrl;
	logic [W-1:0]        param_x, param_y, param_z;
	logic [TW-1:0]       cos_value, sin_value;

	apt3d_regs #(
		.COORD_WIDTH   (COORD_WIDTH),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS),
		.PDATA_W       (PDATA_W),
		.PADDR_W       (PADDR_W)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.ctrl     (ctrl),
		.param_x  (param_x),
		.param_y  (param_y),
		.param_z  (param_z),
		.cos_value(cos_value),
		.sin_value(sin_value)
	);

	assign pready = 1'b1;

	// stage handshake
	logic v1_s1, v2_s2, v3_q;
	logic ready1, ready2, ready3;

	assign ready3   = !v3_q || m_tready;
	assign ready2   = !v2_s2 || ready3;
	assign ready1   = !v1_s1 || ready2;
	assign s_tready = ready1;
	assign m_tvalid = v3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_q  <= 1'b0;
		end else begin
			if (ready1) v1_s1 <= s_tvalid;
			if (ready2) v2_s2 <= v1_s1;
			if (ready3) v3_q  <= v2_s2;
		end
	end

	// stage 1: input register
	logic signed [W-1:0] pt_s1 [3];

	always_ff @(posedge clk) begin
		if (s_tvalid && ready1) begin
			for (int k = 0; k < 3; k++)
				pt_s1[k] <= $signed(s_tdata[k*W +: W]);
		end
	end

	// stage 2: operand select and products
	logic signed [W-1:0]  prm  [3];
	logic signed [MW-1:0] pe   [3];
	logic signed [MW-1:0] prme [3];
	logic signed [W-1:0]  flo  [3];
	logic signed [W:0]    tr   [3];
	logic signed [MW-1:0] c_m, s_m, ns_m;
	logic signed [MW-1:0] opa1 [3], opb1 [3], opa2 [3], opb2 [3];
	logic signed [LW-1:0] lin  [3];
	logic                 use_prod [3];
	logic                 trig_shift;

	assign prm[0] = $signed(param_x);
	assign prm[1] = $signed(param_y);
	assign prm[2] = $signed(param_z);
	assign c_m  = MW'($signed(cos_value));
	assign s_m  = MW'($signed(sin_value));
	assign ns_m = -s_m;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pe[k]   = MW'(pt_s1[k]);
			prme[k] = MW'(prm[k]);
			// offset truncated toward zero to a whole number
			flo[k]  = {prm[k][W-1:COORD_FRAC], {COORD_FRAC{1'b0}}};
			tr[k]   = (W+1)'(flo[k])
				+ ((prm[k][W-1] && (|prm[k][COORD_FRAC-1:0])) ? ONE_T : '0);
			lin[k]      = LW'(pt_s1[k]);
			use_prod[k] = 1'b0;
			opa1[k] = '0;
			opb1[k] = '0;
			opa2[k] = '0;
			opb2[k] = '0;
		end
		trig_shift = 1'b0;
		case (ctrl.mode)
			MODE_TRANSLATE: begin
				for (int k = 0; k < 3; k++)
					lin[k] = LW'(pt_s1[k]) + LW'(tr[k]);
			end
			MODE_SCALE: begin
				for (int k = 0; k < 3; k++) begin
					use_prod[k] = 1'b1;
					opa1[k] = pe[k];
					opb1[k] = prme[k];
				end
			end
			MODE_ROTATE: begin
				trig_shift = 1'b1;
				case (ctrl.axis)
					AXIS_X: begin
						use_prod[1] = 1'b1;
						use_prod[2] = 1'b1;
						opa1[1] = c_m;  opb1[1] = pe[1];
						opa2[1] = ns_m; opb2[1] = pe[2];
						opa1[2] = s_m;  opb1[2] = pe[1];
						opa2[2] = c_m;  opb2[2] = pe[2];
					end
					AXIS_Y: begin
						use_prod[0] = 1'b1;
						use_prod[2] = 1'b1;
						opa1[0] = c_m;  opb1[0] = pe[0];
						opa2[0] = s_m;  opb2[0] = pe[2];
						opa1[2] = ns_m; opb1[2] = pe[0];
						opa2[2] = c_m;  opb2[2] = pe[2];
					end
					AXIS_Z: begin
						use_prod[0] = 1'b1;
						use_prod[1] = 1'b1;
						opa1[0] = c_m;  opb1[0] = pe[0];
						opa2[0] = ns_m; opb2[0] = pe[1];
						opa1[1] = s_m;  opb1[1] = pe[0];
						opa2[1] = c_m;  opb2[1] = pe[1];
					end
					default: ;
				endcase
			end
			MODE_REFLECT: begin
				case (ctrl.plane)
					PLANE_Z: lin[2] = -LW'(pt_s1[2]);
					PLANE_X: lin[0] = -LW'(pt_s1[0]);
					PLANE_Y: lin[1] = -LW'(pt_s1[1]);
					default: ;
				endcase
			end
			MODE_SHEAR: lin[0] = LW'(pt_s1[0]) + LW'(pt_s1[1]);
			default: ;
		endcase
	end

	logic signed [PRW-1:0] prod1_s2 [3], prod2_s2 [3];
	logic signed [LW-1:0]  lin_s2   [3];
	logic                  use_prod_s2 [3];
	logic                  trig_s2;

	always_ff @(posedge clk) begin
		if (v1_s1 && ready2) begin
			for (int k = 0; k < 3; k++) begin
				prod1_s2[k]    <= opa1[k] * opb1[k];
				prod2_s2[k]    <= opa2[k] * opb2[k];
				lin_s2[k]      <= lin[k];
				use_prod_s2[k] <= use_prod[k];
			end
			trig_s2 <= trig_shift;
		end
	end

	// stage 3: sum, shift, saturate
	logic signed [PW-1:0] sum [3], shifted [3], val [3];
	logic signed [W-1:0]  sat [3];
	logic                 fits [3];
	logic                 clip;

	always_comb begin
		clip = 1'b0;
		for (int k = 0; k < 3; k++) begin
			sum[k]     = PW'(prod1_s2[k]) + PW'(prod2_s2[k]);
			shifted[k] = trig_s2 ? (sum[k] >>> TRIG_FRAC_BITS) : (sum[k] >>> COORD_FRAC);
			val[k]     = use_prod_s2[k] ? shifted[k] : PW'(lin_s2[k]);
			fits[k]    = (&val[k][PW-1:W-1]) || !(|val[k][PW-1:W-1]);
			sat[k]     = fits[k] ? val[k][W-1:0] : (val[k][PW-1] ? MINV : MAXV);
			clip       = clip || !fits[k];
		end
	end

	logic signed [W-1:0] out_q [3];
	logic                clip_q;

	always_ff @(posedge clk) begin
		if (v2_s2 && ready3) begin
			for (int k = 0; k < 3; k++)
				out_q[k] <= sat[k];
			clip_q <= clip;
		end
	end

	assign m_tdata = DW'({out_q[2], out_q[1], out_q[0]});
	assign m_tuser = clip_q;

	`APT_CHECK(a_ready_when_drained, m_tready, s_tready, "input stalled while output drains")
	`APT_CHECK(a_full_stall, v1_s1 && v2_s2 && v3_q && !m_tready, !s_tready,
		"input accepted into a full pipeline")
	`APT_CHECK_NEXT(a_stage_advance, v2_s2 && ready3, m_tvalid,
		"product stage advanced without a result")
	`APT_CHECK(a_clip_at_limit, m_tvalid && m_tuser[0],
		out_q[0] == MAXV || out_q[0] == MINV || out_q[1] == MAXV || out_q[1] == MINV ||
		out_q[2] == MAXV || out_q[2] == MINV,
		"clipped flag set without a saturated coordinate")

endmodule

// ----- hdl/apt3d_regs.sv -----
module apt3d_regs
	import apt3d_pkg::*;
#(
	parameter int COORD_WIDTH    = apt3d_pkg::COORD_WIDTH,
	parameter int TRIG_FRAC_BITS = apt3d_pkg::TRIG_FRAC_BITS,
	parameter int PDATA_W        = 32,
	parameter int PADDR_W        = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [PADDR_W-1:0]          paddr,
	input  logic [PDATA_W-1:0]          pwdata,
	output logic [PDATA_W-1:0]          prdata,
	output ctrl_t                       ctrl,
	output logic [COORD_WIDTH-1:0]      param_x,
	output logic [COORD_WIDTH-1:0]      param_y,
	output logic [COORD_WIDTH-1:0]      param_z,
	output logic [TRIG_FRAC_BITS+1:0]   cos_value,
	output logic [TRIG_FRAC_BITS+1:0]   sin_value
);

	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int ADDR_LSB = PADDR_W - 3;
	localparam logic [TW-1:0] COS_RESET = TW'(1) << TRIG_FRAC_BITS;

	ctrl_t             ctrl_q;
	logic [COORD_WIDTH-1:0] px_q, py_q, pz_q;
	logic [TW-1:0]     cos_q, sin_q;
	logic [2:0]        idx;

	assign idx = paddr[ADDR_LSB +: 3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.mode  <= MODE_IDENTITY;
			ctrl_q.axis  <= AXIS_NONE;
			ctrl_q.plane <= PLANE_NONE;
			px_q  <= '0;
			py_q  <= '0;
			pz_q  <= '0;
			cos_q <= COS_RESET;
			sin_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_MODE:    ctrl_q.mode  <= mode_t'(pwdata[2:0]);
				REG_AXIS:    ctrl_q.axis  <= pwdata[1:0];
				REG_PLANE:   ctrl_q.plane <= pwdata[1:0];
				REG_PARAM_X: px_q  <= pwdata[COORD_WIDTH-1:0];
				REG_PARAM_Y: py_q  <= pwdata[COORD_WIDTH-1:0];
				REG_PARAM_Z: pz_q  <= pwdata[COORD_WIDTH-1:0];
				REG_COS:     cos_q <= pwdata[TW-1:0];
				REG_SIN:     sin_q <= pwdata[TW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:    prdata = PDATA_W'(ctrl_q.mode);
			REG_AXIS:    prdata = PDATA_W'(ctrl_q.axis);
			REG_PLANE:   prdata = PDATA_W'(ctrl_q.plane);
			REG_PARAM_X: prdata = PDATA_W'(px_q);
			REG_PARAM_Y: prdata = PDATA_W'(py_q);
			REG_PARAM_Z: prdata = PDATA_W'(pz_q);
			REG_COS:     prdata = PDATA_W'(cos_q);
			REG_SIN:     prdata = PDATA_W'(sin_q);
			default:     prdata = '0;
		endcase
	end

	assign ctrl      = ctrl_q;
	assign param_x   = px_q;
	assign param_y   = py_q;
	assign param_z   = pz_q;
	assign cos_value = cos_q;
	assign sin_value = sin_q;

endmodule

// ----- verif/affine_point_transform_3d_tb.sv -----
`timescale 1ns / 1ps

module affine_point_transform_3d_tb;
	import apt3d_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int DW = ((3 * CW + 7) / 8) * 8;
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;
	localparam int RANDOM_POINTS = 1300;
	localparam int LONG_HOLD = 200;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic signed [CW-1:0] x, y, z;
	} point_t;

	typedef struct {
		logic signed [CW-1:0] x, y, z;
		logic clip;
	} xform_t;

	class transform_scoreboard_t;
		xform_t expected_points[$];
		int mismatches;
		int saturated;
		logic [2:0] mode;
		logic [1:0] axis, plane;
		logic signed [CW-1:0] px, py, pz;
		logic signed [TW-1:0] cos_v, sin_v;

		function new();
			mode = MODE_IDENTITY;
			axis = AXIS_NONE;
			plane = PLANE_NONE;
			px = '0;
			py = '0;
			pz = '0;
			cos_v = TW'(1) <<< TRIG_FRAC_BITS;
			sin_v = '0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_MODE:    mode = val[2:0];
				REG_AXIS:    axis = val[1:0];
				REG_PLANE:   plane = val[1:0];
				REG_PARAM_X: px = val[CW-1:0];
				REG_PARAM_Y: py = val[CW-1:0];
				REG_PARAM_Z: pz = val[CW-1:0];
				REG_COS:     cos_v = val[TW-1:0];
				REG_SIN:     sin_v = val[TW-1:0];
				default: ;
			endcase
		endfunction

		function logic signed [CW-1:0] saturate(longint v, inout logic clip);
			longint hi, lo;
			hi = (longint'(1) <<< (CW - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) begin
				clip = 1'b1;
				v = hi;
			end else if (v < lo) begin
				clip = 1'b1;
				v = lo;
			end
			return v[CW-1:0];
		endfunction

		function xform_t transform_point(point_t p);
			longint x, y, z, ox, oy, oz, c, s, unit;
			xform_t r;
			x = p.x;
			y = p.y;
			z = p.z;
			c = cos_v;
			s = sin_v;
			unit = longint'(1) <<< COORD_FRAC;
			ox = x;
			oy = y;
			oz = z;
			case (mode)
				MODE_TRANSLATE: begin
					// offsets truncate toward zero to whole units
					ox = x + (longint'(px) / unit) * unit;
					oy = y + (longint'(py) / unit) * unit;
					oz = z + (longint'(pz) / unit) * unit;
				end
				MODE_SCALE: begin
					ox = (x * longint'(px)) >>> COORD_FRAC;
					oy = (y * longint'(py)) >>> COORD_FRAC;
					oz = (z * longint'(pz)) >>> COORD_FRAC;
				end
				MODE_ROTATE: begin
					case (axis)
						AXIS_X: begin
							oy = (c * y - s * z) >>> TRIG_FRAC_BITS;
							oz = (s * y + c * z) >>> TRIG_FRAC_BITS;
						end
						AXIS_Y: begin
							ox = (c * x + s * z) >>> TRIG_FRAC_BITS;
							oz = (c * z - s * x) >>> TRIG_FRAC_BITS;
						end
						AXIS_Z: begin
							ox = (c * x - s * y) >>> TRIG_FRAC_BITS;
							oy = (s * x + c * y) >>> TRIG_FRAC_BITS;
						end
						default: ;
					endcase
				end
				MODE_REFLECT: begin
					case (plane)
						PLANE_Z: oz = -z;
						PLANE_X: ox = -x;
						PLANE_Y: oy = -y;
						default: ;
					endcase
				end
				MODE_SHEAR: ox = x + y;
				default: ;
			endcase
			r.clip = 1'b0;
			r.x = saturate(ox, r.clip);
			r.y = saturate(oy, r.clip);
			r.z = saturate(oz, r.clip);
			return r;
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		function void note_error(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] ERROR: %s", $realtime, msg);
		endfunction

		function void note_input(point_t p);
			expected_points.push_back(transform_point(p));
		endfunction

		function void check_result(xform_t got);
			xform_t want;
			if (expected_points.size() == 0) begin
				note_error($sformatf("unexpected result x=%0d y=%0d z=%0d clip=%0b",
					got.x, got.y, got.z, got.clip));
				return;
			end
			want = expected_points.pop_front();
			if (want.clip)
				saturated++;
			if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
					got.clip !== want.clip)
				note_error($sformatf(
					"expected x=%0d y=%0d z=%0d clip=%0b, got x=%0d y=%0d z=%0d clip=%0b",
					want.x, want.y, want.z, want.clip, got.x, got.y, got.z, got.clip));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [DW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DW-1:0] m_tdata;
	logic [0:0] m_tuser;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	transform_scoreboard_t sb;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int stall_requests = 0;
	int stall_served = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int points_in = 0;
	int points_out = 0;
	int settings_used = 0;

	affine_point_transform_3d dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random backpressure, plus a long hold when requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_served != stall_requests) begin
			stall_served = stall_requests;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : stream_watch
		point_t seen;
		xform_t got;
		logic busy;
		if (arst_n) begin
			busy = 1'b0;
			if (s_tvalid && s_tready) begin
				seen.x = s_tdata[CW-1:0];
				seen.y = s_tdata[2*CW-1:CW];
				seen.z = s_tdata[3*CW-1:2*CW];
				sb.note_input(seen);
				points_in++;
				busy = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[CW-1:0];
				got.y = m_tdata[2*CW-1:CW];
				got.z = m_tdata[3*CW-1:2*CW];
				got.clip = m_tuser[0];
				sb.check_result(got);
				points_out++;
				busy = 1'b1;
			end
			if (psel && penable && pready)
				busy = 1'b1;
			if (busy) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("Timeout: no transaction for %0d cycles", idle_cycles);
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	function automatic point_t mk(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic signed [CW-1:0] z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		return p;
	endfunction

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(9))
			0: return CMAX;
			1: return CMIN;
			2: return '0;
			3, 4: return CW'($urandom_range(4096) - 2048);
			default: return CW'($urandom());
		endcase
	endfunction

	function automatic logic signed [TW-1:0] rand_trig();
		case ($urandom_range(7))
			0: return {1'b1, {(TW-1){1'b0}}};
			1: return {1'b0, {(TW-1){1'b1}}};
			2: return TW'(1 <<< TRIG_FRAC_BITS);
			3: return TW'(-(1 <<< TRIG_FRAC_BITS));
			4: return TW'($urandom());
			default: return TW'($urandom_range(2 << TRIG_FRAC_BITS) - (1 << TRIG_FRAC_BITS));
		endcase
	endfunction

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic configure(logic [2:0] mode, logic [1:0] axis, logic [1:0] plane,
			logic signed [CW-1:0] px, logic signed [CW-1:0] py, logic signed [CW-1:0] pz,
			logic signed [TW-1:0] c, logic signed [TW-1:0] s);
		apb_write(REG_MODE, 32'(mode));
		apb_write(REG_AXIS, 32'(axis));
		apb_write(REG_PLANE, 32'(plane));
		apb_write(REG_PARAM_X, 32'(px));
		apb_write(REG_PARAM_Y, 32'(py));
		apb_write(REG_PARAM_Z, 32'(pz));
		apb_write(REG_COS, 32'(c));
		apb_write(REG_SIN, 32'(s));
		settings_used++;
	endtask

	task automatic send_point(point_t p);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= DW'({p.z, p.y, p.x});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// let a clock edge pass first so the last accepted transaction is already counted
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int sent;
		int block_len;
		bit hold_done;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		sb = new();
		tx_idle_pct = 25;
		rx_idle_pct = 58;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: identity
		send_point(mk(CMAX, CMIN, 0));
		send_point(mk(-1, 1, CMIN));
		wait_for_results();

		configure(MODE_RSVD6, AXIS_X, PLANE_X, CMAX, CMAX, CMAX, 16384, 0);
		send_point(mk(CMIN, CMAX, -1));
		wait_for_results();
		configure(MODE_RSVD7, AXIS_Z, PLANE_Y, CMIN, CMIN, CMIN, 0, 16384);
		send_point(mk(CMIN, CMAX, -1));
		wait_for_results();

		// fractional offsets truncate toward zero
		configure(MODE_TRANSLATE, AXIS_NONE, PLANE_NONE, CMAX, -257, CMIN, 16384, 0);
		send_point(mk(CMAX, 0, CMIN));
		send_point(mk(-300, CMIN, 1000));
		wait_for_results();

		configure(MODE_SCALE, AXIS_NONE, PLANE_NONE, CMIN, CMAX, -1, 16384, 0);
		send_point(mk(CMIN, CMAX, CMIN));
		send_point(mk(1, -1, 256));
		wait_for_results();

		// rotation about each axis, with trig patterns inside and outside the unit range
		configure(MODE_ROTATE, AXIS_X, PLANE_NONE, 0, 0, 0, -32768, 32767);
		send_point(mk(CMAX, CMIN, CMAX));
		wait_for_results();
		configure(MODE_ROTATE, AXIS_Y, PLANE_NONE, 0, 0, 0, 11585, 11585);
		send_point(mk(CMAX, 1000, CMIN));
		wait_for_results();
		configure(MODE_ROTATE, AXIS_Z, PLANE_NONE, 0, 0, 0, 0, -16384);
		send_point(mk(CMIN, CMAX, 5));
		wait_for_results();
		configure(MODE_ROTATE, AXIS_NONE, PLANE_NONE, 0, 0, 0, 11585, -11585);
		send_point(mk(123, -456, 789));
		wait_for_results();

		// negating the most negative value saturates
		configure(MODE_REFLECT, AXIS_NONE, PLANE_NONE, 0, 0, 0, 16384, 0);
		send_point(mk(CMIN, CMIN, CMIN));
		wait_for_results();
		configure(MODE_REFLECT, AXIS_NONE, PLANE_Z, 0, 0, 0, 16384, 0);
		send_point(mk(CMIN, CMIN, CMIN));
		wait_for_results();
		configure(MODE_REFLECT, AXIS_NONE, PLANE_X, 0, 0, 0, 16384, 0);
		send_point(mk(CMIN, CMIN, CMIN));
		wait_for_results();
		configure(MODE_REFLECT, AXIS_NONE, PLANE_Y, 0, 0, 0, 16384, 0);
		send_point(mk(CMIN, CMIN, CMIN));
		wait_for_results();

		configure(MODE_SHEAR, AXIS_NONE, PLANE_NONE, 0, 0, 0, 16384, 0);
		send_point(mk(CMAX, CMAX, 0));
		send_point(mk(CMIN, -1, 0));
		send_point(mk(-5, 3, 0));
		wait_for_results();

		sent = 0;
		hold_done = 1'b0;
		while (sent < RANDOM_POINTS) begin
			if (sent < RANDOM_POINTS / 3) begin
				tx_idle_pct = 25;
				rx_idle_pct = 58;
			end else if (sent < 2 * RANDOM_POINTS / 3) begin
				tx_idle_pct = 58;
				rx_idle_pct = 25;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			configure(3'($urandom_range(7)), 2'($urandom_range(3)), 2'($urandom_range(3)),
				rand_coord(), rand_coord(), rand_coord(), rand_trig(), rand_trig());
			block_len = $urandom_range(15, 60);
			repeat (block_len) begin
				// long receiver hold while points keep coming
				if (!hold_done && tx_idle_pct == 0) begin
					stall_requests++;
					hold_done = 1'b1;
				end
				send_point(mk(rand_coord(), rand_coord(), rand_coord()));
				sent++;
			end
			wait_for_results();
		end

		repeat (8) @(posedge clk);
		$display("Checked %0d of %0d points across %0d register settings, %0d saturated.",
			points_out, points_in, settings_used, sb.saturated);
		if (sb.pending() != 0)
			$display("%0d expected results never arrived", sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
